[design/prlb_pkg.sv]
`default_nettype none

package prlb_pkg;

   localparam int MAX_BINS    = 6;
   localparam int BIN_W       = 3;
   localparam int BIN_COUNT_W = 3;
   localparam int LEN_W       = 10;
   localparam int CHAR_W      = 8;
   localparam int CNT_W       = 32;
   localparam int STATUS_W    = 4;
   localparam int PHASE_W     = 2;
   localparam int ROUTE_W     = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   localparam logic [CHAR_W-1:0] CHAR_HEADER    = 8'h40;
   localparam logic [CHAR_W-1:0] CHAR_SEPARATOR = 8'h2B;
   localparam logic [LEN_W-1:0]  SEP_RAW_LEN    = 10'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 4'd0,
      ST_CLEAN_END     = 4'd1,
      ST_FIRST_LONGER  = 4'd2,
      ST_SECOND_LONGER = 4'd3,
      ST_BAD_HDR_1     = 4'd4,
      ST_BAD_HDR_2     = 4'd5,
      ST_BAD_SEP_1     = 4'd6,
      ST_BAD_SEP_2     = 4'd7,
      ST_LEN_MISM_1    = 4'd8,
      ST_LEN_MISM_2    = 4'd9,
      ST_OUT_OF_RANGE  = 4'd10,
      ST_HALTED        = 4'd11
   } status_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_HEADER    = 2'd0,
      PH_SEQUENCE  = 2'd1,
      PH_SEPARATOR = 2'd2,
      PH_QUALITY   = 2'd3
   } phase_type;

   typedef enum logic [ROUTE_W-1:0] {
      ROUTE_NONE    = 2'd0,
      ROUTE_BIN     = 2'd1,
      ROUTE_DISCARD = 2'd2
   } route_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_COUNT = 3'd0,
      CSR_THRESH_0  = 3'd1,
      CSR_THRESH_1  = 3'd2,
      CSR_THRESH_2  = 3'd3,
      CSR_THRESH_3  = 3'd4,
      CSR_THRESH_4  = 3'd5,
      CSR_THRESH_5  = 3'd6,
      CSR_MAX_DIFF  = 3'd7
   } csr_index_type;

   localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RESET = 3'd1;
   localparam logic [LEN_W-1:0]       MAX_DIFF_RESET  = 10'd5;

   typedef struct packed {
      logic [BIN_COUNT_W-1:0]            bin_count;
      logic [MAX_BINS-1:0][LEN_W-1:0]    threshold;
      logic [LEN_W-1:0]                  max_length_diff;
   } cfg_type;

   typedef struct packed {
      status_type       status;
      phase_type        line_phase;
      route_type        route;
      logic [BIN_W-1:0] chosen_bin;
   } item_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

[design/prlb_if.sv]
`default_nettype none

interface prlb_req_if;
   import prlb_pkg::*;
   logic              valid;
   logic              ready;
   logic              first_present;
   logic              second_present;
   logic [CHAR_W-1:0] first_lead_char;
   logic [CHAR_W-1:0] second_lead_char;
   logic [LEN_W-1:0]  first_raw_length;
   logic [LEN_W-1:0]  second_raw_length;
   logic [LEN_W-1:0]  first_content_length;
   logic [LEN_W-1:0]  second_content_length;

   modport source (
      output valid, first_present, second_present, first_lead_char, second_lead_char,
             first_raw_length, second_raw_length, first_content_length,
             second_content_length,
      input  ready
   );
   modport sink (
      input  valid, first_present, second_present, first_lead_char, second_lead_char,
             first_raw_length, second_raw_length, first_content_length,
             second_content_length,
      output ready
   );
endinterface

interface prlb_rsp_if;
   import prlb_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PHASE_W-1:0]  line_phase;
   logic [ROUTE_W-1:0]  route;
   logic [BIN_W-1:0]    chosen_bin;
   logic [CNT_W-1:0]    chosen_bin_total;
   logic [CNT_W-1:0]    discard_total;
   logic [CNT_W-1:0]    pair_total;

   modport source (
      output valid, status, line_phase, route, chosen_bin, chosen_bin_total,
             discard_total, pair_total,
      input  ready
   );
   modport sink (
      input  valid, status, line_phase, route, chosen_bin, chosen_bin_total,
             discard_total, pair_total,
      output ready
   );
endinterface

interface prlb_csr_if;
   import prlb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/prlb_csr.sv]
`default_nettype none

module prlb_csr (
   input  wire logic      clock,
   input  wire logic      reset,
   prlb_csr_if.sink       csr,
   output prlb_pkg::cfg_type cfg
);
   import prlb_pkg::*;

   cfg_type            cfg_ff;
   cfg_type            cfg_in;
   logic [BIN_W-1:0]   thresh_idx;

   assign csr.ready  = 1'b1;
   assign thresh_idx = BIN_W'(csr.index - CSR_IDX_W'(CSR_THRESH_0));
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         priority if (csr.index == CSR_BIN_COUNT) begin
            cfg_in.bin_count = csr.data[BIN_COUNT_W-1:0];
         end else if (csr.index == CSR_MAX_DIFF) begin
            cfg_in.max_length_diff = csr.data[LEN_W-1:0];
         end else begin
            cfg_in.threshold[thresh_idx] = csr.data[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bin_count       <= BIN_COUNT_RESET;
         cfg_ff.threshold       <= '0;
         cfg_ff.max_length_diff <= MAX_DIFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[design/prlb_front.sv]
`default_nettype none

module prlb_front (
   input  wire logic          clock,
   input  wire logic          reset,
   prlb_req_if.sink           req,
   input  wire prlb_pkg::cfg_type cfg,
   output prlb_pkg::item_type item,
   output logic               item_valid,
   input  wire logic          item_ready
);
   import prlb_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  first_seq_ff, first_seq_in;
   logic [LEN_W-1:0]  second_seq_ff, second_seq_in;
   logic              halted_ff, halted_in;
   logic              accept;
   logic [LEN_W-1:0]  diff;
   logic [LEN_W-1:0]  shorter;
   logic [BIN_COUNT_W-1:0] bins_used;
   logic              found;
   logic [BIN_W-1:0]  found_bin;
   phase_type         phase_next;

   assign req.ready  = item_ready;
   assign item_valid = req.valid;
   assign accept     = req.valid && item_ready;

   always_comb begin
      if (req.first_content_length > req.second_content_length) begin
         diff    = req.first_content_length - req.second_content_length;
         shorter = req.second_content_length;
      end else begin
         diff    = req.second_content_length - req.first_content_length;
         shorter = req.first_content_length;
      end
      bins_used = (cfg.bin_count > BIN_COUNT_W'(MAX_BINS)) ?
                  BIN_COUNT_W'(MAX_BINS) : cfg.bin_count;
   end

   // Bins are scanned upward so the highest qualifying bin wins.
   always_comb begin
      found     = 1'b0;
      found_bin = '0;
      for (int i = 0; i < MAX_BINS; i++) begin
         if (BIN_COUNT_W'(i) < bins_used && shorter >= cfg.threshold[i]) begin
            found     = 1'b1;
            found_bin = BIN_W'(i);
         end
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_HEADER:    phase_next = PH_SEQUENCE;
         PH_SEQUENCE:  phase_next = PH_SEPARATOR;
         PH_SEPARATOR: phase_next = PH_QUALITY;
         PH_QUALITY:   phase_next = PH_HEADER;
         default:      phase_next = PH_HEADER;
      endcase
   end

   always_comb begin
      item.status     = ST_OK;
      item.line_phase = phase_ff;
      item.route      = ROUTE_NONE;
      item.chosen_bin = '0;
      first_seq_in    = first_seq_ff;
      second_seq_in   = second_seq_ff;
      priority if (halted_ff) begin
         item.status = ST_HALTED;
      end else if (!req.first_present && !req.second_present) begin
         item.status = ST_CLEAN_END;
      end else if (!req.second_present) begin
         item.status = ST_FIRST_LONGER;
      end else if (!req.first_present) begin
         item.status = ST_SECOND_LONGER;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (req.first_lead_char != CHAR_HEADER) begin
                  item.status = ST_BAD_HDR_1;
               end else if (req.second_lead_char != CHAR_HEADER) begin
                  item.status = ST_BAD_HDR_2;
               end
            end
            PH_SEQUENCE: begin
               first_seq_in  = req.first_raw_length;
               second_seq_in = req.second_raw_length;
            end
            PH_SEPARATOR: begin
               if (req.first_lead_char != CHAR_SEPARATOR ||
                   req.first_raw_length != SEP_RAW_LEN) begin
                  item.status = ST_BAD_SEP_1;
               end else if (req.second_lead_char != CHAR_SEPARATOR ||
                            req.second_raw_length != SEP_RAW_LEN) begin
                  item.status = ST_BAD_SEP_2;
               end
            end
            PH_QUALITY: begin
               if (req.first_raw_length != first_seq_ff) begin
                  item.status = ST_LEN_MISM_1;
               end else if (req.second_raw_length != second_seq_ff) begin
                  item.status = ST_LEN_MISM_2;
               end else if (diff > cfg.max_length_diff) begin
                  item.route = ROUTE_DISCARD;
               end else if (found) begin
                  item.route      = ROUTE_BIN;
                  item.chosen_bin = found_bin;
               end else begin
                  item.status = ST_OUT_OF_RANGE;
               end
            end
            default: begin
               item.status = ST_HALTED;
            end
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      halted_in = halted_ff;
      if (accept) begin
         if (!halted_ff && req.first_present && req.second_present &&
             item.status == ST_OK) begin
            phase_in = phase_next;
         end
         if (item.status != ST_OK && item.status != ST_CLEAN_END &&
             item.status != ST_HALTED) begin
            halted_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         first_seq_ff  <= '0;
         second_seq_ff <= '0;
         halted_ff     <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
         if (accept) begin
            first_seq_ff  <= first_seq_in;
            second_seq_ff <= second_seq_in;
         end
      end
   end

endmodule

`default_nettype wire

[design/prlb_queue.sv]
`default_nettype none

module prlb_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire prlb_pkg::item_type in_item,
   input  wire logic          in_valid,
   output logic               in_ready,
   output prlb_pkg::item_type out_item,
   output logic               out_valid,
   input  wire logic          out_ready
);
   import prlb_pkg::*;

   item_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

[design/prlb_back.sv]
`default_nettype none

module prlb_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire prlb_pkg::item_type item,
   input  wire logic          item_valid,
   output logic               item_ready,
   prlb_rsp_if.source         rsp
);
   import prlb_pkg::*;

   logic [CNT_W-1:0]   bin_totals_ff [MAX_BINS];
   logic [CNT_W-1:0]   discard_ff, discard_in;
   logic [CNT_W-1:0]   pair_ff, pair_in;
   logic [CNT_W-1:0]   bin_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   item_type           rsp_item_ff;
   logic [CNT_W-1:0]   rsp_bin_total_ff, rsp_bin_total_in;
   logic               pop;

   assign item_ready = !rsp_valid_ff || rsp.ready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      discard_in       = discard_ff;
      pair_in          = pair_ff;
      bin_total_in     = sat_inc(bin_totals_ff[item.chosen_bin]);
      rsp_bin_total_in = '0;
      unique case (item.route)
         ROUTE_BIN: begin
            pair_in          = sat_inc(pair_ff);
            rsp_bin_total_in = bin_total_in;
         end
         ROUTE_DISCARD: begin
            pair_in    = sat_inc(pair_ff);
            discard_in = sat_inc(discard_ff);
         end
         default: begin
         end
      endcase
      rsp_valid_in = pop || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         discard_ff   <= '0;
         pair_ff      <= '0;
         for (int i = 0; i < MAX_BINS; i++) begin
            bin_totals_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            discard_ff <= discard_in;
            pair_ff    <= pair_in;
            if (item.route == ROUTE_BIN) begin
               bin_totals_ff[item.chosen_bin] <= bin_total_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff      <= item;
         rsp_bin_total_ff <= rsp_bin_total_in;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.status           = rsp_item_ff.status;
   assign rsp.line_phase       = rsp_item_ff.line_phase;
   assign rsp.route            = rsp_item_ff.route;
   assign rsp.chosen_bin       = rsp_item_ff.chosen_bin;
   assign rsp.chosen_bin_total = rsp_bin_total_ff;
   assign rsp.discard_total    = discard_ff;
   assign rsp.pair_total       = pair_ff;

endmodule

`default_nettype wire

[design/paired_read_length_binner.sv]
// Channel   Direction  Handshake      Payload
// req_if    in         valid/ready    one line summary from each of two streams
// rsp_if    out        valid/ready    status, phase, routing and counters
// csr_if    in         valid/ready    register index and write data
//
// One request is accepted per cycle while the queue has room.
// The front classifies a request in the cycle it is accepted, and the back
// updates the counters while loading the output register.
// A two-entry queue between front and back absorbs response stalls.
// Reset is synchronous and restores registers, counters and line phase.
`default_nettype none

module paired_read_length_binner (
   input  wire logic   clock,
   input  wire logic   reset,
   prlb_req_if.sink    req_if,
   prlb_rsp_if.source  rsp_if,
   prlb_csr_if.sink    csr_if
);
   import prlb_pkg::*;

   cfg_type   cfg;
   item_type  front_item;
   logic      front_valid;
   logic      front_ready;
   item_type  back_item;
   logic      back_valid;
   logic      back_ready;

   prlb_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_if),
      .cfg   (cfg)
   );

   prlb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .cfg        (cfg),
      .item       (front_item),
      .item_valid (front_valid),
      .item_ready (front_ready)
   );

   prlb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (front_item),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_item  (back_item),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   prlb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (back_item),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .rsp        (rsp_if)
   );

endmodule

`default_nettype wire

[design/prlb_checker.sv]
`default_nettype none

module prlb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  rsp_status,
   input wire logic [1:0]  rsp_line_phase,
   input wire logic [1:0]  rsp_route,
   input wire logic [2:0]  rsp_chosen_bin,
   input wire logic [31:0] rsp_chosen_bin_total,
   input wire logic [31:0] rsp_discard_total,
   input wire logic [31:0] rsp_pair_total
);
   import prlb_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_route != ROUTE_NONE |->
         rsp_status == ST_OK && rsp_line_phase == PH_QUALITY)
      else $error("routed pair outside a good quality line");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_route != ROUTE_BIN |->
         rsp_chosen_bin == '0 && rsp_chosen_bin_total == '0)
      else $error("bin fields set without bin routing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_route == ROUTE_BIN |->
         rsp_chosen_bin_total != '0 && rsp_pair_total != '0)
      else $error("routed pair not counted");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pair_total >= rsp_discard_total)
      else $error("discard count exceeds pair count");

endmodule

bind paired_read_length_binner prlb_checker u_prlb_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_status           (rsp_if.status),
   .rsp_line_phase       (rsp_if.line_phase),
   .rsp_route            (rsp_if.route),
   .rsp_chosen_bin       (rsp_if.chosen_bin),
   .rsp_chosen_bin_total (rsp_if.chosen_bin_total),
   .rsp_discard_total    (rsp_if.discard_total),
   .rsp_pair_total       (rsp_if.pair_total)
);

`default_nettype wire
